[design/ssd_pkg.sv]
package ssd_pkg;

  localparam int unsigned NumStages = 4;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [31:0] RecipDiv10 = 32'hCCCC_CCCD;
  localparam logic [31:0] RecipDiv6  = 32'hAAAA_AAAB;
  localparam int unsigned ShiftDiv10 = 35;
  localparam int unsigned ShiftDiv6  = 34;

  typedef enum logic [1:0] {
    MODE_CLOCK = 2'd0,
    MODE_RING  = 2'd1,
    MODE_WATCH = 2'd2,
    MODE_HOLD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_DIV10 = 2'd1,
    OP_DIV6  = 2'd2
  } op_e;

  typedef struct packed {
    logic                  hold;
    logic                  use_ring;
    logic [7:0]            ring_seg;
    logic                  dot_flip;
    logic [1:0]            pos;
    logic [31:0]           value;
    op_e [NumStages-1:0]   ops;
  } cmd_t;

  function automatic logic [7:0] digit_font(logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h3f;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5b;
      4'd3: s = 8'h4f;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6d;
      4'd6: s = 8'h7d;
      4'd7: s = 8'h27;
      4'd8: s = 8'h7f;
      4'd9: s = 8'h67;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] strobe_n(logic [1:0] p);
    logic [7:0] s;
    case (p)
      2'd0: s = 8'h7f;
      2'd1: s = 8'hbf;
      2'd2: s = 8'hdf;
      2'd3: s = 8'hef;
      default: s = 8'hff;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] ring_left(logic [2:0] ph);
    logic [7:0] s;
    case (ph)
      3'd0: s = 8'h20;
      3'd1: s = 8'h10;
      3'd2: s = 8'h08;
      3'd7: s = 8'h01;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] ring_right(logic [2:0] ph);
    logic [7:0] s;
    case (ph)
      3'd3: s = 8'h08;
      3'd4: s = 8'h04;
      3'd5: s = 8'h02;
      3'd6: s = 8'h01;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

[design/ssd_front.sv]
module ssd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         display_mode_i,
  input  logic [31:0]        seconds_i,
  input  logic [31:0]        stopwatch_ms_i,
  input  logic               colon_dot_i,
  input  logic               full_i,
  output logic               push_o,
  output ssd_pkg::cmd_t      cmd_o
);
  import ssd_pkg::*;

  logic [1:0] pos_q, pos_d;
  logic [2:0] phase_q, phase_d;
  mode_e      mode;
  logic       accept;

  assign mode       = mode_e'(display_mode_i);
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign pos_d      = pos_q + 2'd1;
  assign phase_d    = seconds_i[2:0];

  always_comb begin
    cmd_o          = '0;
    cmd_o.hold     = (mode == MODE_HOLD);
    cmd_o.use_ring = (mode == MODE_RING) && pos_q[1];
    cmd_o.ring_seg = pos_q[0] ? ring_left(phase_q) : ring_right(phase_q);
    cmd_o.dot_flip = (mode == MODE_CLOCK) && (pos_q == 2'd2) && colon_dot_i;
    cmd_o.pos      = pos_q;
    cmd_o.value    = ((mode == MODE_WATCH) && !pos_q[1]) ? stopwatch_ms_i : seconds_i;
    for (int k = 0; k < NumStages; k++) begin
      cmd_o.ops[k] = OP_NONE;
    end
    if (mode == MODE_WATCH) begin
      case (pos_q)
        2'd0: begin
          cmd_o.ops[2] = OP_DIV10;
          cmd_o.ops[3] = OP_DIV10;
        end
        2'd1: begin
          cmd_o.ops[1] = OP_DIV10;
          cmd_o.ops[2] = OP_DIV10;
          cmd_o.ops[3] = OP_DIV10;
        end
        2'd2: begin
          cmd_o.ops[3] = OP_DIV10;
        end
        default: begin
          cmd_o.ops[2] = OP_DIV10;
          cmd_o.ops[3] = OP_DIV6;
        end
      endcase
    end else begin
      case (pos_q)
        2'd0: begin
          cmd_o.ops[3] = OP_DIV10;
        end
        2'd1: begin
          cmd_o.ops[2] = OP_DIV10;
          cmd_o.ops[3] = OP_DIV6;
        end
        2'd2: begin
          cmd_o.ops[1] = OP_DIV10;
          cmd_o.ops[2] = OP_DIV6;
          cmd_o.ops[3] = OP_DIV10;
        end
        default: begin
          cmd_o.ops[0] = OP_DIV10;
          cmd_o.ops[1] = OP_DIV6;
          cmd_o.ops[2] = OP_DIV10;
          cmd_o.ops[3] = OP_DIV6;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

endmodule

[design/ssd_fifo.sv]
module ssd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ssd_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ssd_pkg::cmd_t  cmd_o
);
  import ssd_pkg::*;

  cmd_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(FifoDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[design/ssd_div_stage.sv]
module ssd_div_stage (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [31:0]  x_i,
  input  ssd_pkg::op_e op_i,
  output logic [31:0]  quot_o,
  output logic [3:0]   rem_o
);
  import ssd_pkg::*;

  logic [31:0] recip;
  logic [63:0] prod_d, prod_q;
  logic [31:0] x_q;
  op_e         op_q;

  assign recip  = (op_i == OP_DIV6) ? RecipDiv6 : RecipDiv10;
  assign prod_d = 64'(x_i) * 64'(recip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_i;
      prod_q <= prod_d;
      op_q   <= op_i;
    end
  end

  // remainder only needs the low nibble: x - q*d stays below 10
  always_comb begin
    case (op_q)
      OP_DIV10: begin
        quot_o = 32'(prod_q >> ShiftDiv10);
        rem_o  = x_q[3:0] - ({quot_o[0], 3'b000} + {quot_o[2:0], 1'b0});
      end
      OP_DIV6: begin
        quot_o = 32'(prod_q >> ShiftDiv6);
        rem_o  = x_q[3:0] - ({quot_o[1:0], 2'b00} + {quot_o[2:0], 1'b0});
      end
      default: begin
        quot_o = x_q;
        rem_o  = x_q[3:0];
      end
    endcase
  end

endmodule

[design/ssd_back.sv]
module ssd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  ssd_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     segments_o,
  output logic [7:0]     digit_enable_n_o
);
  import ssd_pkg::*;

  logic                 en;
  logic [NumStages-1:0] valid_q;
  cmd_t                 cmd_q [NumStages];
  logic [31:0]          quot [NumStages];
  logic [3:0]           rem  [NumStages];
  logic                 out_valid_q;
  logic [7:0]           seg_q, seg_d;
  logic [7:0]           strobe_q;
  cmd_t                 last;

  assign en        = !out_valid_q || out_ready_i;
  assign cmd_pop_o = en && cmd_valid_i;
  assign last      = cmd_q[NumStages-1];

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    if (k == 0) begin : g_first
      ssd_div_stage u_stage (
        .clk_i  (clk_i),
        .en_i   (en),
        .x_i    (cmd_i.value),
        .op_i   (cmd_i.ops[0]),
        .quot_o (quot[k]),
        .rem_o  (rem[k])
      );
      always_ff @(posedge clk_i) begin
        if (en) begin
          cmd_q[k] <= cmd_i;
        end
      end
    end else begin : g_next
      ssd_div_stage u_stage (
        .clk_i  (clk_i),
        .en_i   (en),
        .x_i    (quot[k-1]),
        .op_i   (cmd_q[k-1].ops[k]),
        .quot_o (quot[k]),
        .rem_o  (rem[k])
      );
      always_ff @(posedge clk_i) begin
        if (en) begin
          cmd_q[k] <= cmd_q[k-1];
        end
      end
    end
  end

  always_comb begin
    if (last.use_ring) begin
      seg_d = last.ring_seg;
    end else begin
      seg_d = digit_font(rem[NumStages-1]) ^ {last.dot_flip, 7'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      seg_q       <= 8'h00;
      strobe_q    <= 8'hff;
    end else if (en) begin
      valid_q     <= {valid_q[NumStages-2:0], cmd_valid_i};
      out_valid_q <= valid_q[NumStages-1];
      if (valid_q[NumStages-1] && !last.hold) begin
        seg_q    <= seg_d;
        strobe_q <= strobe_n(last.pos);
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign segments_o       = seg_q;
  assign digit_enable_n_o = strobe_q;

endmodule

[design/seven_segment_scan_display_top.sv]
// Four-digit multiplexed seven-segment scan driver.
// Slave stream: one transaction per scan tick. tuser carries the display mode,
// tdata carries seconds, the stopwatch millisecond count and the colon flag.
// Master stream: one transaction per tick with the segment pattern of the
// current digit and its active-low strobe; the scan position then advances.
// Result path on an idle block: the queue write at the accepting edge, four
// divide stages (one 32x32 reciprocal multiply each) and the output register.
// Throughput: one tick per cycle, sustained while the receiver is ready.
// A four-entry queue decouples intake from the divide pipeline; when the
// receiver stalls, the pipeline and output hold, the queue fills and then
// s_axis_tready drops.
// Hold mode repeats the last pattern shown. After reset the scan position and
// ring phase are 0, no transaction is pending, and a hold tick shows blank
// segments with all digits off.
module seven_segment_scan_display_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // seconds[31:0], stopwatch_ms[63:32], colon_dot[64], 0
  input  logic [1:0]  s_axis_tuser,  // display_mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // segments[7:0], digit_enable_n[15:8]
);
  import ssd_pkg::*;

  logic full, push, fifo_valid, pop;
  cmd_t front_cmd, fifo_cmd;

  ssd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .display_mode_i (s_axis_tuser),
    .seconds_i      (s_axis_tdata[31:0]),
    .stopwatch_ms_i (s_axis_tdata[63:32]),
    .colon_dot_i    (s_axis_tdata[64]),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (front_cmd)
  );

  ssd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .cmd_o   (fifo_cmd)
  );

  ssd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (fifo_valid),
    .cmd_i            (fifo_cmd),
    .cmd_pop_o        (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .segments_o       (m_axis_tdata[7:0]),
    .digit_enable_n_o (m_axis_tdata[15:8])
  );

endmodule

[design/ssd_checker.sv]
module ssd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic [7:0] strobe;
  assign strobe = m_axis_tdata[15:8];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_strobe_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (strobe == 8'h7f || strobe == 8'hbf || strobe == 8'hdf ||
                       strobe == 8'hef || strobe == 8'hff))
    else $error("digit strobe not a single digit");

  a_blank_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && strobe == 8'hff |-> m_axis_tdata[7:0] == 8'h00)
    else $error("segments lit with all digits off");

  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("intake closed without a transaction");

endmodule

bind seven_segment_scan_display_top ssd_checker u_ssd_checker (.*);

[bench/tb_seven_segment_scan_display_top.sv]
`timescale 1ns / 100ps

module tb_seven_segment_scan_display_top;
  import ssd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TicksPerPhase = 450;
  localparam int unsigned PlanRows = 25;

  // glyph of digit d in byte d, strobe of position p in byte p, ring pattern of phase p in byte p
  localparam logic [79:0] Glyphs = 80'h67_7f_27_7d_6d_66_4f_5b_06_3f;
  localparam logic [31:0] Strobes = 32'hef_df_bf_7f;
  localparam logic [63:0] RingRight = 64'h00_01_02_04_08_00_00_00;
  localparam logic [63:0] RingLeft = 64'h01_00_00_00_00_08_10_20;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] sec;
    logic [31:0] ms;
    logic        dot;
  } tick_t;

  typedef struct packed {
    logic [7:0] seg;
    logic [7:0] en_n;
  } shown_t;

  typedef struct packed {
    tick_t  tick;
    logic   fixed;
    shown_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // seconds[31:0], stopwatch_ms[63:32], colon_dot[64], 0
  logic [1:0]  s_axis_tuser = '0;   // display_mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // segments[7:0], digit_enable_n[15:8]

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned gap_pct = 23;
  int unsigned stall_pct = 65;

  logic [1:0] scan_pos = '0;
  logic [2:0] ring_ph = '0;
  shown_t     held = '{seg: 8'h00, en_n: 8'hff};
  shown_t     shown_q[$];

  row_t plan [PlanRows];

  seven_segment_scan_display_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  function automatic logic [7:0] glyph(input logic [31:0] v);
    return Glyphs[8 * v[3:0] +: 8];
  endfunction

  // display state advances once per accepted tick
  task automatic scan_tick(input tick_t t, output shown_t r);
    logic [7:0] seg;
    seg = 8'h00;
    if (t.mode != MODE_HOLD) begin
      case (t.mode)
        MODE_CLOCK: begin
          case (scan_pos)
            2'd0: seg = glyph(t.sec % 10);
            2'd1: seg = glyph(t.sec / 10 % 6);
            2'd2: seg = glyph(t.sec / 60 % 10) ^ {t.dot, 7'b0};
            default: seg = glyph(t.sec / 600 % 6);
          endcase
        end
        MODE_RING: begin
          case (scan_pos)
            2'd0: seg = glyph(t.sec % 10);
            2'd1: seg = glyph(t.sec / 10 % 6);
            2'd2: seg = RingRight[8 * ring_ph +: 8];
            default: seg = RingLeft[8 * ring_ph +: 8];
          endcase
        end
        default: begin
          case (scan_pos)
            2'd0: seg = glyph(t.ms / 10 % 10);
            2'd1: seg = glyph(t.ms / 100 % 10);
            2'd2: seg = glyph(t.sec % 10);
            default: seg = glyph(t.sec / 10 % 6);
          endcase
        end
      endcase
      held.seg = seg;
      held.en_n = Strobes[8 * scan_pos +: 8];
    end
    r = held;
    scan_pos = scan_pos + 2'd1;
    ring_ph = t.sec[2:0];
  endtask

  task automatic send_tick(input tick_t t, input logic fixed, input shown_t want);
    shown_t r;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, t.dot, t.ms, t.sec};
    s_axis_tuser <= t.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_tick(t, r);
    shown_q.push_back(fixed ? want : r);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (shown_q.size() != 0);
  endtask

  // mostly a running clock with occasional mode changes, the rest unrelated ticks
  task automatic random_ticks(input int unsigned count);
    tick_t t;
    logic [31:0] sec;
    logic [31:0] ms;
    mode_e mode;
    sec = ($urandom_range(3) == 0) ? 32'hffff_fff0 + $urandom_range(15) : $urandom;
    ms = $urandom;
    mode = mode_e'($urandom_range(3));
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(3) == 0) sec = sec + 1;
        if ($urandom_range(63) == 0) sec = $urandom;
        ms = ms + $urandom_range(20);
        if ($urandom_range(15) == 0) mode = mode_e'($urandom_range(3));
        t = '{mode: mode, sec: sec, ms: ms, dot: 1'($urandom_range(1))};
      end else begin
        t = '{mode: mode_e'($urandom_range(3)), sec: $urandom, ms: $urandom,
              dot: 1'($urandom_range(1))};
      end
      send_tick(t, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    shown_t want;
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (shown_q.size() == 0) begin
        $display("%0t: unexpected transaction %04h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = shown_q.pop_front();
        if (m_axis_tdata[7:0] !== want.seg) begin
          $display("%0t: segments expected %02h actual %02h",
                   $time, want.seg, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[15:8] !== want.en_n) begin
          $display("%0t: digit_enable_n expected %02h actual %02h",
                   $time, want.en_n, m_axis_tdata[15:8]);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  initial begin
    plan = '{
      '{'{MODE_HOLD,  32'd7,         32'd0,         1'b0}, 1'b1, '{8'h00, 8'hff}},
      '{'{MODE_RING,  32'd0,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_RING,  32'd3,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_RING,  32'd4,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_CLOCK, 32'hffff_ffff, 32'd0,         1'b0}, 1'b1, '{8'h6d, 8'h7f}},
      '{'{MODE_CLOCK, 32'hffff_ffff, 32'd0,         1'b0}, 1'b1, '{8'h06, 8'hbf}},
      '{'{MODE_CLOCK, 32'hffff_ffff, 32'd0,         1'b1}, 1'b1, '{8'hff, 8'hdf}},
      '{'{MODE_CLOCK, 32'hffff_ffff, 32'd0,         1'b0}, 1'b1, '{8'h5b, 8'hef}},
      '{'{MODE_WATCH, 32'hffff_ffff, 32'hffff_ffff, 1'b1}, 1'b1, '{8'h67, 8'h7f}},
      '{'{MODE_WATCH, 32'hffff_ffff, 32'hffff_ffff, 1'b0}, 1'b1, '{8'h5b, 8'hbf}},
      '{'{MODE_WATCH, 32'hffff_ffff, 32'hffff_ffff, 1'b1}, 1'b1, '{8'h6d, 8'hdf}},
      '{'{MODE_WATCH, 32'hffff_ffff, 32'hffff_ffff, 1'b0}, 1'b1, '{8'h06, 8'hef}},
      '{'{MODE_HOLD,  32'd0,         32'd0,         1'b1}, 1'b1, '{8'h06, 8'hef}},
      '{'{MODE_CLOCK, 32'd0,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_CLOCK, 32'd0,         32'd0,         1'b1}, 1'b0, '0},
      '{'{MODE_RING,  32'd5,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_RING,  32'd6,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_RING,  32'd1,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_RING,  32'd2,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_RING,  32'd7,         32'd0,         1'b1}, 1'b0, '0},
      '{'{MODE_HOLD,  32'd4,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_RING,  32'd5,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_RING,  32'd6,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_RING,  32'd0,         32'd0,         1'b0}, 1'b0, '0},
      '{'{MODE_WATCH, 32'd0,         32'd0,         1'b0}, 1'b0, '0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < PlanRows; i++) begin
      send_tick(plan[i].tick, plan[i].fixed, plan[i].want);
    end
    drain();

    random_ticks(TicksPerPhase);
    drain();
    gap_pct = 65;
    stall_pct = 23;
    random_ticks(TicksPerPhase);
    drain();
    gap_pct = 0;
    stall_pct = 0;
    random_ticks(TicksPerPhase);
    drain();
    repeat (16) @(posedge clk_i);

    if (errors == 0 && shown_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
